// ===== design/car_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_pkg
// Shared constants, codes and arithmetic helpers of the comb/allpass reverb.
// ----------------------------------------------------------------------------
package car_pkg;

  // Default line lengths (samples at 44.1 kHz)
  localparam int COMB_LEN_A_DEF    = 1557;
  localparam int COMB_LEN_B_DEF    = 1617;
  localparam int COMB_LEN_C_DEF    = 1491;
  localparam int COMB_LEN_D_DEF    = 1422;
  localparam int ALLPASS_LEN_A_DEF = 225;
  localparam int ALLPASS_LEN_B_DEF = 556;

  // Line geometry
  localparam int LINE_CAP    = 2048;
  localparam int POS_W       = $clog2(LINE_CAP);
  localparam int LEN_W       = POS_W + 1;
  localparam int CHAN_OFFSET = 23;

  // Coefficient caps
  localparam logic [14:0] COEF_CAP = 15'd32112;
  localparam logic [15:0] GAIN_CAP = 16'd32768;

  // Reset values of the configuration registers
  localparam logic [14:0] ROOM_RST   = 15'd21299;
  localparam logic [14:0] DAMP_RST   = 15'd11469;
  localparam logic [15:0] WET_RST    = 16'd9830;
  localparam logic [15:0] DRY_RST    = 16'd26214;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOM_SIZE = 3'd0,
    CFG_DAMPING   = 3'd1,
    CFG_WET_GAIN  = 3'd2,
    CFG_DRY_GAIN  = 3'd3,
    CFG_STEREO    = 3'd4
  } cfg_idx_t;

  // Wide working width for products and sums
  localparam int ACC_W = 37;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [17:0]      s18_t;

  // Saturate to signed 18 bits
  function automatic s18_t sat18(input acc_t v);
    if (v > acc_t'(131071)) begin
      return 18'sd131071;
    end else if (v < -acc_t'(131072)) begin
      return -18'sd131072;
    end
    return v[17:0];
  endfunction

  // Round half up a Q15 product: add 2^14, floor shift by 15
  function automatic acc_t rnd15(input acc_t v);
    return (v + acc_t'(16384)) >>> 15;
  endfunction

endpackage

// ===== design/car_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_in_if
// Input sample channel: valid/ready with sample, channel and block marker.
// ----------------------------------------------------------------------------
interface car_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;
  logic               channel;
  logic               block_last;

  modport source (output valid, in_sample, channel, block_last, input ready);
  modport sink   (input valid, in_sample, channel, block_last, output ready);
endinterface

// ===== design/car_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_out_if
// Result sample channel: valid/ready with mixed sample, channel and marker.
// ----------------------------------------------------------------------------
interface car_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;
  logic               out_channel;
  logic               out_block_last;

  modport source (output valid, out_sample, out_channel, out_block_last, input ready);
  modport sink   (input valid, out_sample, out_channel, out_block_last, output ready);
endinterface

// ===== design/car_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface car_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== design/car_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module car_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/comb_allpass_reverb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_allpass_reverb_top
// Per-channel reverb: four damped comb lines, averaged, then two allpass
// lines, mixed with the dry sample. Line data lives in two RAMs.
// ----------------------------------------------------------------------------
//  port      dir  handshake      payload
//  in_word   in   valid/ready    in_sample[15:0] s, channel, block_last
//  out_word  out  valid/ready    out_sample[15:0] s, out_channel, out_block_last
//  cfg_word  in   valid/ready    index[2:0], wdata[15:0]
//
//  For each word, each comb is read, filtered and written back
//  through the comb RAM port in 5 steps, each allpass in 2, plus mix and output.
//  After reset a clearing pass zeroes the line RAMs; no input word is taken
//  meanwhile. Configuration writes are always taken.
//  The result waits in an output register; a stalled output holds the sequencer
//  only at its last step.
// ----------------------------------------------------------------------------
module comb_allpass_reverb_top
  import car_pkg::*;
#(
  parameter int COMB_LEN_A    = COMB_LEN_A_DEF,
  parameter int COMB_LEN_B    = COMB_LEN_B_DEF,
  parameter int COMB_LEN_C    = COMB_LEN_C_DEF,
  parameter int COMB_LEN_D    = COMB_LEN_D_DEF,
  parameter int ALLPASS_LEN_A = ALLPASS_LEN_A_DEF,
  parameter int ALLPASS_LEN_B = ALLPASS_LEN_B_DEF
) (
  input logic      clk,
  input logic      rst_n,
  car_in_if.sink   in_word,
  car_out_if.source out_word,
  car_cfg_if.sink  cfg_word
);

  localparam int COMB_DEPTH = 8 * LINE_CAP;
  localparam int AP_DEPTH   = 4 * LINE_CAP;
  localparam int COMB_AW    = $clog2(COMB_DEPTH);
  localparam int AP_AW      = $clog2(AP_DEPTH);

  localparam int BASE_LEN [6] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D,
                                  ALLPASS_LEN_A, ALLPASS_LEN_B};

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CRD, ST_CMUL, ST_CLP, ST_CFB, ST_CWR,
    ST_ARD, ST_AWR, ST_MIX, ST_OUT
  } state_t;

  // Line length with channel offset, capped, never zero
  function automatic logic [LEN_W-1:0] line_len(input logic ch, input logic [2:0] lk);
    int n;
    n = 0;
    for (int i = 0; i < 6; i++) begin
      if (lk == 3'(i)) begin
        n = BASE_LEN[i];
      end
    end
    if (ch) begin
      n = n + CHAN_OFFSET;
    end
    if (n > LINE_CAP) begin
      n = LINE_CAP;
    end
    if (n == 0) begin
      n = 1;
    end
    return LEN_W'(n);
  endfunction

  // Configuration registers
  logic [14:0] room_size_r, damping_r;
  logic [15:0] wet_gain_r, dry_gain_r;
  logic        stereo_r;

  // Sequencer and datapath registers
  state_t             state_r;
  logic [COMB_AW:0]   clr_cnt_r;
  logic [1:0]         k_r;
  logic signed [15:0] x_r;
  logic               ch_r, last_r;
  acc_t               p1_r, p2_r, p3_r;
  logic signed [19:0] sum_r;
  s18_t               rev_r;
  acc_t               m1_r, m2_r;
  s18_t               lp_r [8];
  logic [POS_W-1:0]   pos_r [12];
  logic               out_valid_r;
  logic signed [15:0] out_sample_r;
  logic               out_ch_r, out_last_r;

  // RAM ports
  logic               comb_we, ap_we;
  logic [COMB_AW-1:0] comb_addr;
  logic [AP_AW-1:0]   ap_addr;
  logic [17:0]        comb_wdata, ap_wdata, comb_rdata, ap_rdata;

  // Capped coefficients
  logic [14:0] room_c, damp_c;
  logic [15:0] wet_c, dry_c;
  logic [16:0] one_m_damp;

  assign room_c     = (room_size_r > COEF_CAP) ? COEF_CAP : room_size_r;
  assign damp_c     = (damping_r > COEF_CAP) ? COEF_CAP : damping_r;
  assign wet_c      = (wet_gain_r > GAIN_CAP) ? GAIN_CAP : wet_gain_r;
  assign dry_c      = (dry_gain_r > GAIN_CAP) ? GAIN_CAP : dry_gain_r;
  assign one_m_damp = 17'd32768 - {2'b00, damp_c};

  // Current line, its pointer and its advanced pointer
  logic              in_ap;
  logic [2:0]        lk;
  logic [3:0]        pidx;
  logic [2:0]        ci;
  logic [1:0]        ai;
  logic [LEN_W-1:0]  len;
  logic [POS_W-1:0]  pos_cur, pos_eff, pos_adv;
  logic [LEN_W-1:0]  pos_inc;

  assign in_ap   = (state_r == ST_ARD) || (state_r == ST_AWR);
  assign lk      = in_ap ? {2'b10, k_r[0]} : {1'b0, k_r};
  assign pidx    = ch_r ? (4'd6 + {1'b0, lk}) : {1'b0, lk};
  assign ci      = {ch_r, k_r};
  assign ai      = {ch_r, k_r[0]};
  assign len     = line_len(ch_r, lk);
  assign pos_cur = pos_r[pidx];
  assign pos_eff = ({1'b0, pos_cur} >= len) ? '0 : pos_cur;
  assign pos_inc = {1'b0, pos_eff} + LEN_W'(1);
  assign pos_adv = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];

  // Datapath arithmetic
  s18_t comb_dly, ap_dly, lp_new, comb_wr, ap_wr, ap_rev;
  acc_t mix_sum;
  logic signed [15:0] y_sat;

  assign comb_dly = comb_rdata;
  assign ap_dly   = ap_rdata;
  assign lp_new   = sat18(rnd15(p1_r) + rnd15(p2_r));
  assign comb_wr  = sat18(acc_t'(x_r) + rnd15(p3_r));
  assign ap_wr    = sat18(acc_t'(rev_r) + ((acc_t'(ap_dly) + acc_t'(1)) >>> 1));
  assign ap_rev   = sat18(acc_t'(ap_dly) - acc_t'(rev_r));
  assign mix_sum  = rnd15(m1_r + m2_r);

  always_comb begin
    if (mix_sum > acc_t'(32767)) begin
      y_sat = 16'sd32767;
    end else if (mix_sum < -acc_t'(32768)) begin
      y_sat = -16'sd32768;
    end else begin
      y_sat = mix_sum[15:0];
    end
  end

  // RAM port muxing
  always_comb begin
    comb_we    = 1'b0;
    ap_we      = 1'b0;
    comb_addr  = {ci, pos_eff};
    ap_addr    = {ai, pos_eff};
    comb_wdata = comb_wr;
    ap_wdata   = ap_wr;
    if (state_r == ST_CLEAR) begin
      comb_we    = 1'b1;
      ap_we      = 1'b1;
      comb_addr  = clr_cnt_r[COMB_AW-1:0];
      ap_addr    = clr_cnt_r[AP_AW-1:0];
      comb_wdata = '0;
      ap_wdata   = '0;
    end else if (state_r == ST_CWR) begin
      comb_we = 1'b1;
    end else if (state_r == ST_AWR) begin
      ap_we = 1'b1;
    end
  end

  car_ram #(.WIDTH(18), .DEPTH(COMB_DEPTH)) u_comb_ram (
    .clk   (clk),
    .we    (comb_we),
    .addr  (comb_addr),
    .wdata (comb_wdata),
    .rdata (comb_rdata)
  );

  car_ram #(.WIDTH(18), .DEPTH(AP_DEPTH)) u_ap_ram (
    .clk   (clk),
    .we    (ap_we),
    .addr  (ap_addr),
    .wdata (ap_wdata),
    .rdata (ap_rdata)
  );

  // Handshakes
  logic in_fire, out_fire, cfg_fire, out_load;

  assign in_word.ready  = (state_r == ST_IDLE);
  assign cfg_word.ready = 1'b1;
  assign in_fire        = in_word.valid && in_word.ready;
  assign cfg_fire       = cfg_word.valid;
  assign out_fire       = out_valid_r && out_word.ready;
  assign out_load       = (state_r == ST_OUT) && (!out_valid_r || out_word.ready);

  assign out_word.valid          = out_valid_r;
  assign out_word.out_sample     = out_sample_r;
  assign out_word.out_channel    = out_ch_r;
  assign out_word.out_block_last = out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_size_r <= ROOM_RST;
      damping_r   <= DAMP_RST;
      wet_gain_r  <= WET_RST;
      dry_gain_r  <= DRY_RST;
      stereo_r    <= 1'b1;
    end else if (cfg_fire) begin
      unique case (cfg_word.index)
        CFG_ROOM_SIZE: room_size_r <= cfg_word.wdata[14:0];
        CFG_DAMPING:   damping_r   <= cfg_word.wdata[14:0];
        CFG_WET_GAIN:  wet_gain_r  <= cfg_word.wdata;
        CFG_DRY_GAIN:  dry_gain_r  <= cfg_word.wdata;
        CFG_STEREO:    stereo_r    <= cfg_word.wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer, line state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        lp_r[i] <= '0;
      end
      for (int i = 0; i < 12; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      // output taken and nothing new loaded behind it
      if (out_fire && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r[COMB_AW-1:0] == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            x_r     <= in_word.in_sample;
            ch_r    <= stereo_r ? in_word.channel : 1'b0;
            last_r  <= in_word.block_last;
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= ST_CRD;
          end
        end
        ST_CRD: state_r <= ST_CMUL;
        ST_CMUL: begin
          // delayed sample arrives: lowpass products and comb sum
          p1_r    <= acc_t'(comb_dly) * acc_t'({1'b0, one_m_damp});
          p2_r    <= acc_t'(lp_r[ci]) * acc_t'({1'b0, damp_c});
          sum_r   <= sum_r + 20'(comb_dly);
          state_r <= ST_CLP;
        end
        ST_CLP: begin
          lp_r[ci] <= lp_new;
          state_r  <= ST_CFB;
        end
        ST_CFB: begin
          p3_r    <= acc_t'(lp_r[ci]) * acc_t'({1'b0, room_c});
          state_r <= ST_CWR;
        end
        ST_CWR: begin
          // write back feedback and step the pointer
          pos_r[pidx] <= pos_adv;
          k_r         <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            rev_r   <= 18'((sum_r + 20'sd2) >>> 2);
            state_r <= ST_ARD;
          end else begin
            state_r <= ST_CRD;
          end
        end
        ST_ARD: state_r <= ST_AWR;
        ST_AWR: begin
          pos_r[pidx] <= pos_adv;
          rev_r       <= ap_rev;
          k_r         <= k_r + 1'b1;
          if (k_r[0]) begin
            state_r <= ST_MIX;
          end else begin
            state_r <= ST_ARD;
          end
        end
        ST_MIX: begin
          m1_r    <= acc_t'(x_r) * acc_t'({1'b0, dry_c});
          m2_r    <= acc_t'(rev_r) * acc_t'({1'b0, wet_c});
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= y_sat;
            out_ch_r     <= ch_r;
            out_last_r   <= last_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
